>>> design/lambert_fragment_shader_unit_defines.svh
// assertion macros for the lambert fragment shader unit
`ifndef LAMBERT_FRAGMENT_SHADER_UNIT_DEFINES_SVH
`define LAMBERT_FRAGMENT_SHADER_UNIT_DEFINES_SVH

// condition must hold in the same cycle
`define LFS_ASSERT_HOLDS(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("lfs assertion failed");

// condition must be followed by expr a fixed number of cycles later
`define LFS_ASSERT_DELAY(label, cond, n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> ##(n) (expr)) \
        else $error("lfs latency assertion failed");

`endif

>>> design/lfs_pkg.sv
// types and constants of the lambert fragment shader unit
package lfs_pkg;

    typedef struct packed {
        logic signed [31:0] frag_x;
        logic signed [31:0] frag_y;
        logic signed [31:0] frag_z;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic [15:0]        texel_red;
        logic [15:0]        texel_green;
        logic [15:0]        texel_blue;
        logic [15:0]        texel_alpha;
    } frag_in_t;

    typedef struct packed {
        logic [15:0] out_red;
        logic [15:0] out_green;
        logic [15:0] out_blue;
        logic [15:0] out_alpha;
    } frag_out_t;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
    } color_t;

    // travels with each fragment behind the dot product stage
    typedef struct packed {
        logic        active;
        logic [33:0] num;
        color_t      base;
    } carry_t;

    typedef enum logic [2:0] {
        REG_LIGHT_X        = 3'd0,
        REG_LIGHT_Y        = 3'd1,
        REG_LIGHT_Z        = 3'd2,
        REG_DIFFUSE_RED    = 3'd3,
        REG_DIFFUSE_GREEN  = 3'd4,
        REG_DIFFUSE_BLUE   = 3'd5,
        REG_DIFFUSE_ALPHA  = 3'd6,
        REG_TEXTURE_ENABLE = 3'd7
    } cfg_reg_t;

    localparam int unsigned SQRT_BITS = 17;
    localparam int unsigned QUOT_BITS = 18;
    localparam logic [16:0] AMBIENT_Q16 = 17'd13107;
    localparam logic [17:0] ONE_Q16 = 18'd65536;
    localparam logic [15:0] UNORM_MAX = 16'hffff;

endpackage

>>> design/lambert_fragment_shader_unit.sv
// lambert fragment shader unit: top level, fully pipelined
//
// One fragment request is taken in every cycle; busy stays low. Each result
// appears on result with done high for one cycle, in request order. The
// pipeline holds two bit-per-stage units: a 17-stage square root for the
// vector lengths and an 18-stage divider for the cosine, plus eight stages of
// subtract, magnitude, block normalize, multiply, sum, denominator, overflow
// check and shade. Configuration writes through cfg_we/cfg_index/cfg_data
// take effect at once and must only happen while no request is in flight.
module lambert_fragment_shader_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lfs_pkg::frag_in_t request,
    output logic              done,
    output lfs_pkg::frag_out_t result,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import lfs_pkg::*;

    `include "lambert_fragment_shader_unit_defines.svh"

    localparam int unsigned LATENCY = 5 + SQRT_BITS + 2 + QUOT_BITS + 1;

    function automatic logic [5:0] msb_pos(input logic [32:0] v);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 33; i++)
        begin
            if (v[i])
            begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

    // moves the vector so its largest magnitude has its top bit at bit 15
    function automatic logic [15:0] norm_shift(input logic [32:0] m, input logic [5:0] p);
        logic [32:0] r;
        if (p >= 6'd15)
        begin
            r = m >> (p - 6'd15);
        end
        else
        begin
            r = m << (6'd15 - p);
        end
        return r[15:0];
    endfunction

    function automatic logic [15:0] shade(input logic [15:0] base, input logic [16:0] factor);
        logic [32:0] prod;
        prod = 33'(base) * 33'(factor);
        return (prod[32] != 1'b0) ? UNORM_MAX : prod[31:16];
    endfunction

    // configuration
    logic [31:0] light_reg [3];
    color_t      diffuse_reg;
    logic        texture_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_reg[0]       <= '0;
            light_reg[1]       <= '0;
            light_reg[2]       <= '0;
            diffuse_reg        <= {UNORM_MAX, UNORM_MAX, UNORM_MAX, UNORM_MAX};
            texture_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LIGHT_X:        light_reg[0] <= cfg_data;
                REG_LIGHT_Y:        light_reg[1] <= cfg_data;
                REG_LIGHT_Z:        light_reg[2] <= cfg_data;
                REG_DIFFUSE_RED:    diffuse_reg.red <= cfg_data[15:0];
                REG_DIFFUSE_GREEN:  diffuse_reg.green <= cfg_data[15:0];
                REG_DIFFUSE_BLUE:   diffuse_reg.blue <= cfg_data[15:0];
                REG_DIFFUSE_ALPHA:  diffuse_reg.alpha <= cfg_data[15:0];
                REG_TEXTURE_ENABLE: texture_enable_reg <= cfg_data[0];
                default:            texture_enable_reg <= texture_enable_reg;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage a: light vector, normal, base colour
    logic        a_vld_reg;
    logic [32:0] a_vec_reg [2][3];
    color_t      a_base_reg;
    logic [31:0] frag_pos [3];
    logic [31:0] frag_nrm [3];

    assign frag_pos[0] = request.frag_x;
    assign frag_pos[1] = request.frag_y;
    assign frag_pos[2] = request.frag_z;
    assign frag_nrm[0] = request.normal_x;
    assign frag_nrm[1] = request.normal_y;
    assign frag_nrm[2] = request.normal_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_vec_reg[0][i] <= {light_reg[i][31], light_reg[i]} - {frag_pos[i][31], frag_pos[i]};
            a_vec_reg[1][i] <= {frag_nrm[i][31], frag_nrm[i]};
        end
        if (texture_enable_reg)
        begin
            a_base_reg <= {request.texel_red, request.texel_green,
                           request.texel_blue, request.texel_alpha};
        end
        else
        begin
            a_base_reg <= diffuse_reg;
        end
    end

    // stage b: magnitudes and signs
    logic        b_vld_reg;
    logic [32:0] b_mag_reg [2][3];
    logic        b_neg_reg [2][3];
    color_t      b_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else
        begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int v = 0; v < 2; v++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                b_neg_reg[v][i] <= a_vec_reg[v][i][32];
                b_mag_reg[v][i] <= a_vec_reg[v][i][32] ? (33'd0 - a_vec_reg[v][i])
                                                       : a_vec_reg[v][i];
            end
        end
        b_base_reg <= a_base_reg;
    end

    // stage c: block normalization
    logic        c_vld_reg;
    logic [15:0] c_mag_reg [2][3];
    logic        c_neg_reg [2][3];
    logic        c_nz_reg [2];
    color_t      c_base_reg;
    logic [32:0] b_or [2];
    logic [5:0]  b_pos [2];

    always_comb
    begin
        for (int v = 0; v < 2; v++)
        begin
            b_or[v]  = b_mag_reg[v][0] | b_mag_reg[v][1] | b_mag_reg[v][2];
            b_pos[v] = msb_pos(b_or[v]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
        end
        else
        begin
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int v = 0; v < 2; v++)
        begin
            c_nz_reg[v] <= b_or[v] != '0;
            for (int i = 0; i < 3; i++)
            begin
                c_neg_reg[v][i] <= b_neg_reg[v][i];
                c_mag_reg[v][i] <= norm_shift(b_mag_reg[v][i], b_pos[v]);
            end
        end
        c_base_reg <= b_base_reg;
    end

    // stage d: products
    logic        d_vld_reg;
    logic [31:0] d_dot_reg [3];
    logic        d_dneg_reg [3];
    logic [31:0] d_sq_reg [2][3];
    logic        d_nz_reg;
    color_t      d_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg <= 1'b0;
        end
        else
        begin
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_dot_reg[i]   <= 32'(c_mag_reg[0][i]) * 32'(c_mag_reg[1][i]);
            d_dneg_reg[i]  <= c_neg_reg[0][i] ^ c_neg_reg[1][i];
            d_sq_reg[0][i] <= 32'(c_mag_reg[0][i]) * 32'(c_mag_reg[0][i]);
            d_sq_reg[1][i] <= 32'(c_mag_reg[1][i]) * 32'(c_mag_reg[1][i]);
        end
        d_nz_reg   <= c_nz_reg[0] && c_nz_reg[1];
        d_base_reg <= c_base_reg;
    end

    // stage e: sums, first entry of the square root chain
    logic signed [34:0] d_dot_sum;
    logic [33:0]        d_len_sum [2];

    always_comb
    begin
        d_dot_sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (d_dneg_reg[i])
            begin
                d_dot_sum = d_dot_sum - $signed({3'b000, d_dot_reg[i]});
            end
            else
            begin
                d_dot_sum = d_dot_sum + $signed({3'b000, d_dot_reg[i]});
            end
        end
        for (int v = 0; v < 2; v++)
        begin
            d_len_sum[v] = 34'(d_sq_reg[v][0]) + 34'(d_sq_reg[v][1]) + 34'(d_sq_reg[v][2]);
        end
    end

    logic        sq_vld_reg [SQRT_BITS + 1];
    carry_t      sq_car_reg [SQRT_BITS + 1];
    logic [33:0] sq_rem_reg [SQRT_BITS + 1][2];
    logic [16:0] sq_root_reg [SQRT_BITS + 1][2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg[0] <= 1'b0;
        end
        else
        begin
            sq_vld_reg[0] <= d_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_car_reg[0].active <= d_nz_reg && (d_dot_sum > 35'sd0);
        sq_car_reg[0].num    <= d_dot_sum[33:0];
        sq_car_reg[0].base   <= d_base_reg;
        for (int v = 0; v < 2; v++)
        begin
            sq_rem_reg[0][v]  <= d_len_sum[v];
            sq_root_reg[0][v] <= '0;
        end
    end

    // square root, one result bit per stage, both lengths side by side
    for (genvar k = 0; k < SQRT_BITS; k++)
    begin : g_sqrt
        localparam int unsigned BIT = SQRT_BITS - 1 - k;
        logic [35:0] trial [2];

        always_comb
        begin
            for (int v = 0; v < 2; v++)
            begin
                trial[v] = (36'(sq_root_reg[k][v]) << (BIT + 1)) + (36'd1 << (2 * BIT));
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[k + 1] <= 1'b0;
            end
            else
            begin
                sq_vld_reg[k + 1] <= sq_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            sq_car_reg[k + 1] <= sq_car_reg[k];
            for (int v = 0; v < 2; v++)
            begin
                if (36'(sq_rem_reg[k][v]) >= trial[v])
                begin
                    sq_rem_reg[k + 1][v]  <= sq_rem_reg[k][v] - trial[v][33:0];
                    sq_root_reg[k + 1][v] <= sq_root_reg[k][v] | (17'd1 << BIT);
                end
                else
                begin
                    sq_rem_reg[k + 1][v]  <= sq_rem_reg[k][v];
                    sq_root_reg[k + 1][v] <= sq_root_reg[k][v];
                end
            end
        end
    end

    // stage f: denominator
    logic        f_vld_reg;
    carry_t      f_car_reg;
    logic [33:0] f_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
        end
        else
        begin
            f_vld_reg <= sq_vld_reg[SQRT_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        f_car_reg <= sq_car_reg[SQRT_BITS];
        f_den_reg <= 34'(sq_root_reg[SQRT_BITS][0]) * 34'(sq_root_reg[SQRT_BITS][1]);
    end

    // stage g: overflow check, first entry of the divider
    logic        dv_vld_reg [QUOT_BITS + 1];
    carry_t      dv_car_reg [QUOT_BITS + 1];
    logic [51:0] dv_rem_reg [QUOT_BITS + 1];
    logic [33:0] dv_den_reg [QUOT_BITS + 1];
    logic [17:0] dv_quo_reg [QUOT_BITS + 1];
    logic        dv_ovf_reg [QUOT_BITS + 1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_vld_reg[0] <= 1'b0;
        end
        else
        begin
            dv_vld_reg[0] <= f_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dv_car_reg[0] <= f_car_reg;
        dv_rem_reg[0] <= {2'b00, f_car_reg.num, 16'd0};
        dv_den_reg[0] <= f_den_reg;
        dv_quo_reg[0] <= '0;
        dv_ovf_reg[0] <= {2'b00, f_car_reg.num, 16'd0} >= {f_den_reg, 18'd0};
    end

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < QUOT_BITS; k++)
    begin : g_div
        localparam int unsigned BIT = QUOT_BITS - 1 - k;
        logic [51:0] shifted;

        assign shifted = 52'(dv_den_reg[k]) << BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[k + 1] <= 1'b0;
            end
            else
            begin
                dv_vld_reg[k + 1] <= dv_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            dv_car_reg[k + 1] <= dv_car_reg[k];
            dv_den_reg[k + 1] <= dv_den_reg[k];
            dv_ovf_reg[k + 1] <= dv_ovf_reg[k];
            if (dv_rem_reg[k] >= shifted)
            begin
                dv_rem_reg[k + 1] <= dv_rem_reg[k] - shifted;
                dv_quo_reg[k + 1] <= dv_quo_reg[k] | (18'd1 << BIT);
            end
            else
            begin
                dv_rem_reg[k + 1] <= dv_rem_reg[k];
                dv_quo_reg[k + 1] <= dv_quo_reg[k];
            end
        end
    end

    // stage h: clamp, ambient and shading
    carry_t      h_car;
    logic [17:0] h_cos;
    logic [16:0] h_factor;

    always_comb
    begin
        h_car = dv_car_reg[QUOT_BITS];
        if (!h_car.active)
        begin
            h_cos = '0;
        end
        else if (dv_ovf_reg[QUOT_BITS] || (dv_quo_reg[QUOT_BITS] > ONE_Q16))
        begin
            h_cos = ONE_Q16;
        end
        else
        begin
            h_cos = dv_quo_reg[QUOT_BITS];
        end
        h_factor = AMBIENT_Q16 + h_cos[16:0];
    end

    logic      done_reg;
    frag_out_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_vld_reg[QUOT_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.out_red   <= shade(h_car.base.red, h_factor);
        result_reg.out_green <= shade(h_car.base.green, h_factor);
        result_reg.out_blue  <= shade(h_car.base.blue, h_factor);
        result_reg.out_alpha <= h_car.base.alpha;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // an active fragment always has two nonzero lengths
    `LFS_ASSERT_HOLDS(a_den_nonzero, f_vld_reg && f_car_reg.active, f_den_reg != '0)
    `LFS_ASSERT_DELAY(a_latency, start && !busy, LATENCY, done)
    `LFS_ASSERT_DELAY(a_no_spurious, !start, LATENCY, !done)

endmodule
